// ===== hdl/pbb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pbb_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 256;

   localparam int HANDLE_W = 16;
   localparam int BYTES_W  = 16;
   localparam int BUDGET_W = 24;
   localparam int STATUS_W = 3;

   localparam logic [BUDGET_W-1:0] RESET_BUFFER_BYTES = 24'd65536;

   localparam logic ACT_ENQUEUE = 1'b0;
   localparam logic ACT_DEQUEUE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_ENQUEUED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DROP_BYTES = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DROP_FULL  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DEQUEUED   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;     // capture the accepted request
      logic commit;   // execute it and load the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic rsp_busy; // result register holds an unclaimed transaction
   } stat_type;

endpackage

`default_nettype wire

// ===== hdl/pbb_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pbb_ctrl (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_tvalid,
   output logic               req_tready,
   input  wire                rsp_tready,
   input  pbb_pkg::stat_type  stat,
   output pbb_pkg::cmd_type   cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff;
   logic state_in;
   logic slot_free;

   assign slot_free  = !stat.rsp_busy || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // The result can only be produced once the output register has room.
            if (slot_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/pbb_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pbb_datapath #(
   parameter int QUEUE_DEPTH = pbb_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  pbb_pkg::cmd_type                    cmd,
   output pbb_pkg::stat_type                   stat,
   input  wire                                 in_action,
   input  wire  [pbb_pkg::HANDLE_W-1:0]        in_handle,
   input  wire  [pbb_pkg::BYTES_W-1:0]         in_bytes,
   input  wire                                 in_is_ack,
   input  wire                                 csr_wr_en,
   input  wire  [pbb_pkg::BUDGET_W-1:0]        csr_wr_data,
   input  wire                                 rsp_tready,
   output logic                                rsp_valid,
   output logic [pbb_pkg::STATUS_W-1:0]        rsp_status,
   output logic [pbb_pkg::HANDLE_W-1:0]        rsp_handle,
   output logic [pbb_pkg::BYTES_W-1:0]         rsp_bytes,
   output logic                                rsp_was_ack,
   output logic [pbb_pkg::BUDGET_W-1:0]        rsp_used
);

   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int WORD_W = pbb_pkg::HANDLE_W + pbb_pkg::BYTES_W;
   localparam int BW     = pbb_pkg::BUDGET_W;

   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   logic [WORD_W-1:0] ack_mem  [QUEUE_DEPTH];
   logic [WORD_W-1:0] data_mem [QUEUE_DEPTH];

   logic [WORD_W-1:0] ack_rd_ff, data_rd_ff;

   logic [PTR_W-1:0] ack_head_ff, ack_head_in, ack_tail_ff, ack_tail_in;
   logic [PTR_W-1:0] data_head_ff, data_head_in, data_tail_ff, data_tail_in;
   logic [CNT_W-1:0] ack_count_ff, ack_count_in, data_count_ff, data_count_in;
   logic [BW-1:0]    held_ff, held_in;
   logic [BW-1:0]    budget_ff;

   logic                          item_action_ff;
   logic [pbb_pkg::HANDLE_W-1:0]  item_handle_ff;
   logic [pbb_pkg::BYTES_W-1:0]   item_bytes_ff;
   logic                          item_is_ack_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [pbb_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic [pbb_pkg::HANDLE_W-1:0]  handle_ff, handle_in;
   logic [pbb_pkg::BYTES_W-1:0]   bytes_ff, bytes_in;
   logic                          was_ack_ff, was_ack_in;
   logic [BW-1:0]                 used_ff;

   logic [BW-1:0]      free_bytes;
   logic [BW-1:0]      item_bytes_ext;
   logic [BW-1:0]      pop_bytes_ext;
   logic               target_full;
   logic               ack_wr, data_wr;
   logic [WORD_W-1:0]  enq_word;
   logic [WORD_W-1:0]  pop_word;

   assign item_bytes_ext = BW'(item_bytes_ff);
   assign free_bytes     = (budget_ff > held_ff) ? (budget_ff - held_ff) : '0;
   assign target_full    = item_is_ack_ff ? (ack_count_ff == FULL_CNT)
                                          : (data_count_ff == FULL_CNT);
   assign enq_word       = {item_handle_ff, item_bytes_ff};
   assign pop_word       = (ack_count_ff != '0) ? ack_rd_ff : data_rd_ff;
   assign pop_bytes_ext  = BW'(pop_word[pbb_pkg::BYTES_W-1:0]);

   always_comb begin
      ack_head_in   = ack_head_ff;
      ack_tail_in   = ack_tail_ff;
      ack_count_in  = ack_count_ff;
      data_head_in  = data_head_ff;
      data_tail_in  = data_tail_ff;
      data_count_in = data_count_ff;
      held_in       = held_ff;
      ack_wr        = 1'b0;
      data_wr       = 1'b0;
      status_in     = pbb_pkg::ST_EMPTY;
      handle_in     = '0;
      bytes_in      = '0;
      was_ack_in    = 1'b0;
      if (item_action_ff == pbb_pkg::ACT_ENQUEUE) begin
         priority if (free_bytes < item_bytes_ext) begin
            status_in = pbb_pkg::ST_DROP_BYTES;
         end else if (target_full) begin
            status_in = pbb_pkg::ST_DROP_FULL;
         end else begin
            status_in = pbb_pkg::ST_ENQUEUED;
            held_in   = held_ff + item_bytes_ext;
            if (item_is_ack_ff) begin
               ack_wr       = cmd.commit;
               ack_tail_in  = (ack_tail_ff == LAST_PTR) ? '0 : ack_tail_ff + 1'b1;
               ack_count_in = ack_count_ff + 1'b1;
            end else begin
               data_wr       = cmd.commit;
               data_tail_in  = (data_tail_ff == LAST_PTR) ? '0 : data_tail_ff + 1'b1;
               data_count_in = data_count_ff + 1'b1;
            end
         end
      end else begin
         priority if (ack_count_ff != '0) begin
            status_in    = pbb_pkg::ST_DEQUEUED;
            was_ack_in   = 1'b1;
            ack_head_in  = (ack_head_ff == LAST_PTR) ? '0 : ack_head_ff + 1'b1;
            ack_count_in = ack_count_ff - 1'b1;
         end else if (data_count_ff != '0) begin
            status_in     = pbb_pkg::ST_DEQUEUED;
            data_head_in  = (data_head_ff == LAST_PTR) ? '0 : data_head_ff + 1'b1;
            data_count_in = data_count_ff - 1'b1;
         end else begin
            status_in = pbb_pkg::ST_EMPTY;
         end
         if (status_in == pbb_pkg::ST_DEQUEUED) begin
            handle_in = pop_word[WORD_W-1:pbb_pkg::BYTES_W];
            bytes_in  = pop_word[pbb_pkg::BYTES_W-1:0];
            held_in   = (held_ff > pop_bytes_ext) ? (held_ff - pop_bytes_ext) : '0;
         end
      end
   end

   assign rsp_valid_in  = cmd.commit || (rsp_valid_ff && !rsp_tready);
   assign stat.rsp_busy = rsp_valid_ff;

   // The queue memories are never cleared; an entry is only read after it was written.
   // Each head entry is read every cycle, so its data is ready the cycle after the
   // head or the memory changes, which the idle state between transactions covers.
   always_ff @(posedge clock) begin
      if (ack_wr) begin
         ack_mem[ack_tail_ff] <= enq_word;
      end
      ack_rd_ff <= ack_mem[ack_head_ff];
   end

   always_ff @(posedge clock) begin
      if (data_wr) begin
         data_mem[data_tail_ff] <= enq_word;
      end
      data_rd_ff <= data_mem[data_head_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_action_ff <= in_action;
         item_handle_ff <= in_handle;
         item_bytes_ff  <= in_bytes;
         item_is_ack_ff <= in_is_ack;
      end
      if (cmd.commit) begin
         status_ff  <= status_in;
         handle_ff  <= handle_in;
         bytes_ff   <= bytes_in;
         was_ack_ff <= was_ack_in;
         used_ff    <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ack_head_ff   <= '0;
         ack_tail_ff   <= '0;
         ack_count_ff  <= '0;
         data_head_ff  <= '0;
         data_tail_ff  <= '0;
         data_count_ff <= '0;
         held_ff       <= '0;
         budget_ff     <= pbb_pkg::RESET_BUFFER_BYTES;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.commit) begin
            ack_head_ff   <= ack_head_in;
            ack_tail_ff   <= ack_tail_in;
            ack_count_ff  <= ack_count_in;
            data_head_ff  <= data_head_in;
            data_tail_ff  <= data_tail_in;
            data_count_ff <= data_count_in;
            held_ff       <= held_in;
         end
         if (csr_wr_en) begin
            budget_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = status_ff;
   assign rsp_handle  = handle_ff;
   assign rsp_bytes   = bytes_ff;
   assign rsp_was_ack = was_ack_ff;
   assign rsp_used    = used_ff;

endmodule

`default_nettype wire

// ===== hdl/priority_byte_buffer_two_class.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Content
// req_      in         req_tvalid/req_tready  enqueue or dequeue request
// rsp_      out        rsp_tvalid/rsp_tready  status, dequeued packet, used bytes
// csr_      in         csr_wr_en              buffer_bytes budget write
//
// A transaction is accepted while the controller is idle and executed in the
// execute state that follows, when the queue heads are already read from
// the registered memory ports. The result register lets the next
// transaction be accepted while a result waits; execution stalls only while
// it is full and rsp_tready is low. Synchronous reset empties both queues,
// clears the byte count and sets the budget to 65536; memories are not swept.

module priority_byte_buffer_two_class #(
   parameter int QUEUE_DEPTH = pbb_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // packet_handle[15:0], packet_bytes[31:16]
   input  wire  [1:0]  req_tuser,   // action[0], is_ack[1]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [55:0] rsp_tdata,   // out_handle[15:0], out_bytes[31:16], used_bytes[55:32]
   output logic [3:0]  rsp_tuser,   // status[2:0], out_was_ack[3]
   input  wire         csr_wr_en,
   input  wire  [23:0] csr_wr_data  // buffer_bytes
);

   pbb_pkg::cmd_type  cmd;
   pbb_pkg::stat_type stat;

   logic [pbb_pkg::STATUS_W-1:0] rsp_status;
   logic [pbb_pkg::HANDLE_W-1:0] rsp_handle;
   logic [pbb_pkg::BYTES_W-1:0]  rsp_bytes;
   logic                         rsp_was_ack;
   logic [pbb_pkg::BUDGET_W-1:0] rsp_used;

   pbb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   pbb_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .in_action   (req_tuser[0]),
      .in_handle   (req_tdata[15:0]),
      .in_bytes    (req_tdata[31:16]),
      .in_is_ack   (req_tuser[1]),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tready  (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_status  (rsp_status),
      .rsp_handle  (rsp_handle),
      .rsp_bytes   (rsp_bytes),
      .rsp_was_ack (rsp_was_ack),
      .rsp_used    (rsp_used)
   );

   assign rsp_tdata = {rsp_used, rsp_bytes, rsp_handle};
   assign rsp_tuser = {rsp_was_ack, rsp_status};

endmodule

`default_nettype wire
